/* rtl/jmsr_pkg.sv */
// shared types and constants for the jpeg marker stream repair unit
// no dependencies; imported by every module in rtl/
package jmsr_pkg;

    // default depth of the queue between the parser and the emitter
    localparam int CMD_DEPTH = 4;

    // parser modes
    localparam logic [2:0] M_PREFIX  = 3'd0;
    localparam logic [2:0] M_MARKER  = 3'd1;
    localparam logic [2:0] M_LEN_HI  = 3'd2;
    localparam logic [2:0] M_LEN_LO  = 3'd3;
    localparam logic [2:0] M_PAYLOAD = 3'd4;
    localparam logic [2:0] M_SCAN    = 3'd5;
    localparam logic [2:0] M_PASS    = 3'd6;
    localparam logic [2:0] M_DONE    = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_NO_PREFIX = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // marker and fill bytes
    localparam logic [7:0] B_PREFIX = 8'hFF;
    localparam logic [7:0] B_SOI    = 8'hD8;
    localparam logic [7:0] B_DROP   = 8'hA0;
    localparam logic [7:0] B_SOF    = 8'hC0;
    localparam logic [7:0] B_DHT    = 8'hC4;
    localparam logic [7:0] B_DQT    = 8'hDB;
    localparam logic [7:0] B_SOS    = 8'hDA;
    localparam logic [7:0] B_APP    = 8'hE0;
    localparam logic [7:0] B_EOI    = 8'hD9;
    localparam logic [7:0] B_ZERO   = 8'h00;
    localparam logic [7:0] B_SOS_LEN = 8'h0C;
    localparam logic [7:0] B_SE     = 8'h3F;

    // one parsed input beat: up to four result bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;     // result bytes in order
        logic [1:0]      last_idx;  // index of the final result of this beat
        logic            stat_only; // single status-only result
        logic [2:0]      status;    // status carried by the final result
        logic            end_flag;  // final result ends the stream
    } t_cmd;

endpackage

/* rtl/jpeg_marker_stream_repair_unit.sv */
// jpeg marker stream repair unit: parser, command queue and result emitter
// a byte accepted is written into the command queue, then its first result is
// loaded into the output register, from which it can be popped
// throughput: one input byte per cycle while the queue has room; a byte with
// k results gives k output beats; the queue absorbs short bursts of up to QUEUE_DEPTH commands
// reset: synchronous active-low i_rst_n clears parser mode, queue and output
// depends on jmsr_pkg, jmsr_front, jmsr_cmd_fifo, jmsr_back
module jpeg_marker_stream_repair_unit
    import jmsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte stream
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // repaired stream
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic [2:0] o_status
);

    logic q_full, q_empty;
    logic accept;
    logic cmd_push, cmd_pop;
    t_cmd cmd_in, cmd_head;

    // a beat is taken whenever the queue has room; beats that cause no
    // result still advance the parser but push nothing
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: marker parsing, length tracking, scan stuffing decisions
    jmsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // decoupling queue so either side can stall on its own
    jmsr_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: one result beat per cycle into the output register while it is empty or popped
    jmsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_head),
        .i_cmd_valid  (!q_empty),
        .o_cmd_pop    (cmd_pop),
        .pop          (pop),
        .empty        (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_status     (o_status)
    );

endmodule

/* rtl/jmsr_front.sv */
// parser: classifies each input byte and builds at most one command per beat
// depends on jmsr_pkg
module jmsr_front
    import jmsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [2:0]  r_mode, n_mode;
    logic        r_seg_kind, n_seg_kind;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_remain, n_remain;
    logic [7:0]  r_held_byte, n_held_byte;
    logic        r_held_valid, n_held_valid;

    logic [2:0]  cnt;
    logic [3:0][7:0] bytes;
    logic        stat_only;
    logic [2:0]  status;
    logic        ended;
    logic        scan_cut;
    logic [15:0] len;
    logic [15:0] rem_dec;

    assign len     = {r_len_hi, i_in_byte};
    assign rem_dec = r_remain - 16'd1;

    always_comb begin
        n_mode       = r_mode;
        n_seg_kind   = r_seg_kind;
        n_len_hi     = r_len_hi;
        n_remain     = r_remain;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        cnt          = 3'd0;
        bytes        = '0;
        stat_only    = 1'b0;
        status       = ST_OK;
        ended        = 1'b0;
        scan_cut     = 1'b0;

        case (r_mode)
            M_PREFIX: begin
                if (i_in_byte == B_PREFIX) begin
                    n_mode = M_MARKER;
                end else begin
                    cnt = 3'd1; stat_only = 1'b1; status = ST_NO_PREFIX; ended = 1'b1;
                end
            end
            M_MARKER: begin
                case (i_in_byte)
                    B_SOI: begin
                        bytes[0] = B_PREFIX; bytes[1] = B_SOI; cnt = 3'd2;
                        n_mode = M_PREFIX;
                    end
                    B_DROP: begin
                        n_mode = M_PREFIX;
                    end
                    B_SOF, B_DHT, B_DQT: begin
                        bytes[0] = B_PREFIX; bytes[1] = i_in_byte; cnt = 3'd2;
                        n_seg_kind = 1'b0;
                        n_mode = M_LEN_HI;
                    end
                    B_SOS: begin
                        bytes[0] = B_PREFIX; bytes[1] = B_SOS;
                        bytes[2] = B_ZERO;   bytes[3] = B_SOS_LEN; cnt = 3'd4;
                        n_seg_kind = 1'b1;
                        n_mode = M_LEN_HI;
                    end
                    B_APP: begin
                        bytes[0] = B_PREFIX; bytes[1] = B_APP; cnt = 3'd2;
                        n_mode = M_PASS;
                    end
                    B_EOI: begin
                        bytes[0] = B_PREFIX; bytes[1] = B_EOI; cnt = 3'd2;
                        ended = 1'b1;
                    end
                    default: begin
                        cnt = 3'd1; stat_only = 1'b1; status = ST_UNKNOWN; ended = 1'b1;
                    end
                endcase
            end
            M_LEN_HI: begin
                n_len_hi = i_in_byte;
                if (!r_seg_kind) begin
                    bytes[0] = i_in_byte; cnt = 3'd1;
                end
                n_mode = M_LEN_LO;
            end
            M_LEN_LO: begin
                if (len < 16'd2) begin
                    cnt = 3'd1; stat_only = 1'b1; status = ST_BAD_LEN; ended = 1'b1;
                end else begin
                    if (!r_seg_kind) begin
                        bytes[0] = i_in_byte; cnt = 3'd1;
                    end
                    n_remain = len - 16'd2;
                    if (n_remain != 16'd0) begin
                        n_mode = M_PAYLOAD;
                    end else if (!r_seg_kind) begin
                        n_mode = M_PREFIX;
                    end else begin
                        scan_cut = 1'b1;
                    end
                end
            end
            M_PAYLOAD: begin
                bytes[0] = i_in_byte; cnt = 3'd1;
                n_remain = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (r_seg_kind) begin
                        scan_cut = 1'b1;
                    end else begin
                        n_mode = M_PREFIX;
                    end
                end
            end
            M_SCAN: begin
                if (i_in_last) begin
                    bytes[0] = B_PREFIX; bytes[1] = B_EOI; cnt = 3'd2;
                    ended = 1'b1;
                end else begin
                    if (r_held_valid) begin
                        bytes[0] = r_held_byte; cnt = 3'd1;
                        // byte stuffing
                        if (r_held_byte == B_PREFIX) begin
                            bytes[1] = B_ZERO; cnt = 3'd2;
                        end
                    end
                    n_held_byte  = i_in_byte;
                    n_held_valid = 1'b1;
                end
            end
            M_PASS: begin
                bytes[0] = i_in_byte; cnt = 3'd1;
            end
            default: begin
            end
        endcase

        // end of scan header: spectral selection tail, then scan data
        if (scan_cut) begin
            if (!i_in_last) begin
                if (cnt == 3'd0) begin
                    bytes[0] = B_ZERO; bytes[1] = B_SE; bytes[2] = B_ZERO;
                end else begin
                    bytes[1] = B_ZERO; bytes[2] = B_SE; bytes[3] = B_ZERO;
                end
                cnt = cnt + 3'd3;
            end
            n_held_valid = 1'b0;
            n_held_byte  = B_ZERO;
            n_mode       = M_SCAN;
        end

        if (r_mode != M_DONE && !ended && i_in_last) begin
            if (n_mode != M_PASS) begin
                if (cnt != 3'd0) begin
                    status = ST_TRUNC;
                end else begin
                    cnt = 3'd1; stat_only = 1'b1; status = ST_TRUNC;
                end
            end
            ended = 1'b1;
        end

        if (ended) begin
            n_mode = M_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_PREFIX;
            r_seg_kind   <= 1'b0;
            r_len_hi     <= '0;
            r_remain     <= '0;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_seg_kind   <= n_seg_kind;
            r_len_hi     <= n_len_hi;
            r_remain     <= n_remain;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
        end
    end

    assign o_cmd_push     = i_accept && (cnt != 3'd0);
    assign o_cmd.bytes    = bytes;
    assign o_cmd.last_idx = 2'(cnt - 3'd1);
    assign o_cmd.stat_only = stat_only;
    assign o_cmd.status   = status;
    assign o_cmd.end_flag = ended;

endmodule

/* rtl/jmsr_cmd_fifo.sv */
// short register queue of parsed commands between parser and emitter
// depends on jmsr_pkg (t_cmd)
module jmsr_cmd_fifo
    import jmsr_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/jmsr_back.sv */
// emitter: expands each queued command into result beats, one per cycle while the output register is empty or popped
// depends on jmsr_pkg (t_cmd, status codes)
module jmsr_back
    import jmsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_stream_end,
    output logic [2:0] o_status
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_byte_valid, r_run_last, r_stream_end;
    logic [2:0] r_status;
    logic       advance, is_last;

    assign advance   = i_cmd_valid && (!r_out_valid || pop);
    assign is_last   = (r_idx == i_cmd.last_idx);
    assign o_cmd_pop = advance && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte       <= i_cmd.stat_only ? B_ZERO : i_cmd.bytes[r_idx];
            r_byte_valid <= !i_cmd.stat_only;
            r_run_last   <= is_last;
            r_stream_end <= is_last && i_cmd.end_flag;
            r_status     <= is_last ? i_cmd.status : ST_OK;
        end
    end

    assign empty        = !r_out_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;
    assign o_status     = r_status;

endmodule
